/* rtl/gdr_pkg.sv */
// Shared constants and types of the grid DDA column raycaster.
package gdr_pkg;

  localparam int SCREEN_W   = 640;
  localparam int SCREEN_H   = 480;
  localparam int MAP_SIDE   = 64;
  localparam int MAP_W      = 6;
  localparam int MAP_CELLS  = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_W     = 2 * MAP_W;
  localparam int STEP_LIMIT = 4 * MAP_SIDE + 8;
  localparam int CNT_W      = 9;
  localparam int HEIGHT_CAP = 2 * SCREEN_H;
  localparam int HALF_H     = SCREEN_H / 2;

  localparam int DIV_N   = 31;
  localparam int DIV_D   = 50;
  localparam int SIDE_W  = 50;
  localparam int DELTA_W = 41;
  localparam logic [DELTA_W-1:0] DELTA_INF = DELTA_W'(1) << 40;

  localparam logic [23:0] COLOR_X_SIDE = 24'hAAAAAA;
  localparam logic [23:0] COLOR_Y_SIDE = 24'h777777;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 22;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_DIR_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_X    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_Y    = 3'd5;

  localparam logic KIND_MAP  = 1'b0;
  localparam logic KIND_CAST = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [5:0]  cell_row;
    logic [5:0]  cell_col;
    logic        cell_is_wall;
    logic [9:0]  screen_column;
  } gdr_item_t;

  typedef struct packed {
    logic        valid;
    gdr_item_t   item;
  } gdr_head_t;

  typedef struct packed {
    logic        pop;
    logic        clr_busy;
  } gdr_ctl_t;

  typedef struct packed {
    logic [21:0]        player_x;
    logic [21:0]        player_y;
    logic signed [15:0] view_dir_x;
    logic signed [15:0] view_dir_y;
    logic signed [15:0] cam_plane_x;
    logic signed [15:0] cam_plane_y;
  } gdr_cfg_t;

endpackage

/* rtl/gdr_front.sv */
// Input stage: takes items, drops casts of columns off screen, and queues the rest.
module gdr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [5:0]        cell_row_i,
  input  logic [5:0]        cell_col_i,
  input  logic              cell_is_wall_i,
  input  logic [9:0]        screen_column_i,
  input  gdr_pkg::gdr_ctl_t ctl_i,
  output gdr_pkg::gdr_head_t head_o
);
  import gdr_pkg::*;

  gdr_item_t  fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       accept, keep, push, pop;
  gdr_item_t  item;

  assign item = '{kind: kind_i, cell_row: cell_row_i, cell_col: cell_col_i,
                  cell_is_wall: cell_is_wall_i, screen_column: screen_column_i};

  assign in_stall_o = (cnt_q == 2'd2) || ctl_i.clr_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign keep       = (kind_i == KIND_MAP) || (screen_column_i < 10'(SCREEN_W));
  assign push       = accept && keep;
  assign pop        = ctl_i.pop && (cnt_q != 2'd0);

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.item  = fifo_q[rd_q];

endmodule

/* rtl/gdr_div.sv */
// Restoring divider that produces one quotient bit per cycle.
module gdr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gdr_pkg::DIV_N-1:0] dividend_i,
  input  logic [gdr_pkg::DIV_D-1:0] divisor_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [gdr_pkg::DIV_N-1:0] quot_o
);
  import gdr_pkg::*;

  logic [DIV_N-1:0] quo_q;
  logic [DIV_D:0]   rem_q, rem_sh;
  logic [DIV_D-1:0] den_q;
  logic [4:0]       cnt_q;
  logic             busy_q, done_q, ge;

  assign rem_sh = {rem_q[DIV_D-1:0], quo_q[DIV_N-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_N-2:0], ge};
      rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(DIV_N - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

/* rtl/gdr_back.sv */
// Execution stage: map memory, ray setup, DDA walk and slice computation.
module gdr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gdr_pkg::gdr_cfg_t  cfg_i,
  input  gdr_pkg::gdr_head_t head_i,
  output gdr_pkg::gdr_ctl_t  ctl_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [9:0]         out_column_o,
  output logic [8:0]         slice_top_o,
  output logic [8:0]         slice_bottom_o,
  output logic [23:0]        slice_color_o,
  output logic               hit_y_side_o
);
  import gdr_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CAM, S_MUL, S_RAY, S_DX, S_DY, S_SIDEX, S_SIDEY,
    S_STEP, S_CHECK, S_DIST, S_H, S_OUT
  } st_e;

  localparam logic signed [7:0] MapLim   = 8'(MAP_SIDE);
  localparam logic [15:0]       CamRecip = 16'd52429;

  st_e                 st_q;
  logic [9:0]          scol_q;
  logic signed [15:0]  cam_q;
  logic signed [31:0]  px_q, py_q;
  logic signed [18:0]  rx_q, ry_q;
  logic [DELTA_W-1:0]  dx_q, dy_q;
  logic [SIDE_W-1:0]   sx_q, sy_q, dist_q;
  logic signed [7:0]   mx_q, my_q;
  logic                ys_q, inr_q, rd_q, run_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [9:0]          lh_q;
  logic [ADDR_W-1:0]   clr_q;
  logic                out_valid_q, out_ys_q;
  logic [9:0]          out_col_q;
  logic [8:0]          out_top_q, out_bot_q;

  logic                mem_q [MAP_CELLS];
  logic                mem_we, mem_wd;
  logic [ADDR_W-1:0]   mem_wa, rd_addr;

  logic signed [12:0]  sn;
  logic [9:0]          sabs;
  logic [25:0]         cam_prod;
  logic [14:0]         cam_mag;
  logic [18:0]         ax, ay;
  logic                div_start, div_busy, div_done;
  logic [DIV_N-1:0]    div_dvd, div_q;
  logic [DIV_D-1:0]    div_dvs;
  logic                step_x;
  logic signed [7:0]   nmx, nmy;
  logic [16:0]         fr;
  logic [30:0]         md;
  logic [47:0]         mprod;
  logic [SIDE_W-1:0]   side_new;
  logic                m_neg, m_inf;
  logic [15:0]         frac;
  logic [8:0]          half;
  logic [9:0]          top_w, bot_w;
  logic                load_out;

  assign sn   = $signed({2'b00, scol_q, 1'b0}) - 13'sd640;
  assign sabs = sn[12] ? 10'(-sn) : sn[9:0];
  assign ax   = rx_q[18] ? 19'(-rx_q) : 19'(rx_q);
  assign ay   = ry_q[18] ? 19'(-ry_q) : 19'(ry_q);

  // The camera offset |2*col - width| * 2^14 / width reduces to |..| * 128 / 5. The
  // reciprocal of five scaled by 2^18 gives the exact floor for these operands.
  assign cam_prod = sabs * CamRecip;
  assign cam_mag  = cam_prod[25:11];

  always_comb begin
    div_dvd = '0;
    div_dvs = '0;
    case (st_q)
      S_DX: begin
        div_dvd = DIV_N'(1) << 30;
        div_dvs = DIV_D'(ax);
      end
      S_DY: begin
        div_dvd = DIV_N'(1) << 30;
        div_dvs = DIV_D'(ay);
      end
      S_H: begin
        div_dvd = DIV_N'(SCREEN_H) << 16;
        div_dvs = dist_q;
      end
      default: ;
    endcase
  end

  assign div_start = !run_q && !div_busy &&
                     ((st_q == S_DX && ax != '0) ||
                      (st_q == S_DY && ay != '0) || (st_q == S_H && dist_q != '0));

  gdr_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dvd),
    .divisor_i (div_dvs),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quot_o    (div_q)
  );

  // One multiplier is shared by the two starting side distances.
  assign m_neg = (st_q == S_SIDEX) ? rx_q[18] : ry_q[18];
  assign frac  = (st_q == S_SIDEX) ? cfg_i.player_x[15:0] : cfg_i.player_y[15:0];
  assign m_inf = (st_q == S_SIDEX) ? (dx_q == DELTA_INF) : (dy_q == DELTA_INF);
  assign md    = (st_q == S_SIDEX) ? dx_q[30:0] : dy_q[30:0];
  assign fr    = m_neg ? {1'b0, frac} : 17'h10000 - {1'b0, frac};
  assign mprod = fr * md;
  assign side_new = m_inf ? (SIDE_W'(fr) << 24) : SIDE_W'(mprod >> 16);

  // A tie between the side sums steps along y.
  assign step_x  = sx_q < sy_q;
  assign nmx     = step_x ? (rx_q[18] ? mx_q - 8'sd1 : mx_q + 8'sd1) : mx_q;
  assign nmy     = step_x ? my_q : (ry_q[18] ? my_q - 8'sd1 : my_q + 8'sd1);
  assign rd_addr = {nmy[MAP_W-1:0], nmx[MAP_W-1:0]};

  assign mem_we = (st_q == S_CLEAR) ||
                  (st_q == S_IDLE && head_i.valid && head_i.item.kind == KIND_MAP);
  assign mem_wa = (st_q == S_CLEAR) ? clr_q
                                    : {head_i.item.cell_row, head_i.item.cell_col};
  assign mem_wd = (st_q == S_CLEAR) ? 1'b0 : head_i.item.cell_is_wall;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rd_q <= mem_q[rd_addr];
  end

  assign half  = lh_q[9:1];
  assign top_w = (half > 9'(HALF_H)) ? 10'd0 : 10'(HALF_H) - 10'(half);
  assign bot_w = (10'(HALF_H) + 10'(half) >= 10'(SCREEN_H)) ? 10'(SCREEN_H - 1)
                                                             : 10'(HALF_H) + 10'(half);
  assign load_out = (st_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_CLEAR;
      clr_q       <= '0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      scol_q      <= '0;
      cam_q       <= '0;
      px_q        <= '0;
      py_q        <= '0;
      rx_q        <= '0;
      ry_q        <= '0;
      dx_q        <= '0;
      dy_q        <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      mx_q        <= '0;
      my_q        <= '0;
      ys_q        <= 1'b0;
      inr_q       <= 1'b0;
      dist_q      <= '0;
      lh_q        <= '0;
      out_col_q   <= '0;
      out_top_q   <= '0;
      out_bot_q   <= '0;
      out_ys_q    <= 1'b0;
    end else begin
      if (div_start) run_q <= 1'b1;
      if (div_done) run_q <= 1'b0;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == ADDR_W'(MAP_CELLS - 1)) st_q <= S_IDLE;
        end
        S_IDLE: begin
          if (head_i.valid && head_i.item.kind == KIND_CAST) begin
            scol_q <= head_i.item.screen_column;
            st_q   <= S_CAM;
          end
        end
        S_CAM: begin
          cam_q <= sn[12] ? -$signed({1'b0, cam_mag}) : $signed({1'b0, cam_mag});
          st_q  <= S_MUL;
        end
        S_MUL: begin
          px_q <= cfg_i.cam_plane_x * cam_q;
          py_q <= cfg_i.cam_plane_y * cam_q;
          st_q <= S_RAY;
        end
        S_RAY: begin
          rx_q <= 19'(px_q >>> 14) + 19'(cfg_i.view_dir_x);
          ry_q <= 19'(py_q >>> 14) + 19'(cfg_i.view_dir_y);
          st_q <= S_DX;
        end
        S_DX: begin
          if (ax == '0) begin
            dx_q <= DELTA_INF;
            st_q <= S_DY;
          end else if (div_done) begin
            dx_q <= DELTA_W'(div_q);
            st_q <= S_DY;
          end
        end
        S_DY: begin
          if (ay == '0) begin
            dy_q <= DELTA_INF;
            st_q <= S_SIDEX;
          end else if (div_done) begin
            dy_q <= DELTA_W'(div_q);
            st_q <= S_SIDEX;
          end
        end
        S_SIDEX: begin
          sx_q <= side_new;
          mx_q <= 8'(cfg_i.player_x[21:16]);
          my_q <= 8'(cfg_i.player_y[21:16]);
          st_q <= S_SIDEY;
        end
        S_SIDEY: begin
          sy_q  <= side_new;
          cnt_q <= '0;
          st_q  <= S_STEP;
        end
        S_STEP: begin
          if (step_x) begin
            sx_q <= sx_q + SIDE_W'(dx_q);
          end else begin
            sy_q <= sy_q + SIDE_W'(dy_q);
          end
          ys_q  <= !step_x;
          mx_q  <= nmx;
          my_q  <= nmy;
          inr_q <= (nmx >= 8'sd0) && (nmx < MapLim) && (nmy >= 8'sd0) && (nmy < MapLim);
          cnt_q <= cnt_q + 1'b1;
          st_q  <= S_CHECK;
        end
        S_CHECK: begin
          if (!inr_q || rd_q || cnt_q == CNT_W'(STEP_LIMIT)) begin
            st_q <= S_DIST;
          end else begin
            st_q <= S_STEP;
          end
        end
        S_DIST: begin
          dist_q <= ys_q ? sy_q - SIDE_W'(dy_q) : sx_q - SIDE_W'(dx_q);
          st_q   <= S_H;
        end
        S_H: begin
          if (dist_q == '0) begin
            lh_q <= 10'(HEIGHT_CAP);
            st_q <= S_OUT;
          end else if (div_done) begin
            lh_q <= (div_q > DIV_N'(HEIGHT_CAP)) ? 10'(HEIGHT_CAP) : div_q[9:0];
            st_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (load_out) begin
            out_col_q <= scol_q;
            out_top_q <= top_w[8:0];
            out_bot_q <= bot_w[8:0];
            out_ys_q  <= ys_q;
            st_q      <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign ctl_o.pop      = (st_q == S_IDLE) && head_i.valid;
  assign ctl_o.clr_busy = (st_q == S_CLEAR);

  assign out_valid_o    = out_valid_q;
  assign out_column_o   = out_col_q;
  assign slice_top_o    = out_top_q;
  assign slice_bottom_o = out_bot_q;
  assign slice_color_o  = out_ys_q ? COLOR_Y_SIDE : COLOR_X_SIDE;
  assign hit_y_side_o   = out_ys_q;

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy) else $error("divider restarted while busy");

  a_out_from_slice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(st_q) == S_OUT)
    else $error("result appeared outside slice state");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_STEP |-> cnt_q < CNT_W'(STEP_LIMIT)) else $error("step limit overrun");

  a_walk_near_map: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_CHECK |-> (mx_q >= -8'sd1 && mx_q <= MapLim && my_q >= -8'sd1 &&
                         my_q <= MapLim))
    else $error("walk left the map by more than one cell");

endmodule

/* rtl/grid_dda_column_raycaster.sv */
// Top level of the grid DDA column raycaster: configuration registers, front and back.
//
//  Channel | Handshake                 | Payload
//  --------+---------------------------+---------------------------------------------------
//  in      | in_valid_i / in_stall_o   | kind, cell_row, cell_col, cell_is_wall, screen_column
//  out     | out_valid_o / out_stall_i | out_column, slice_top, slice_bottom, slice_color,
//          |                           | hit_y_side
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// The back end writes a map item in S_IDLE as it pops it. A cast makes three divisions
// (two deltas, line height) on one shared serial divider, and a zero ray component or
// zero distance skips its division; each grid step passes through S_STEP and S_CHECK.
// After reset the map is cleared one cell per cycle, with in_stall_o high.
// A two-entry queue separates input from execution, and a result register lets the
// next cast run while a finished slice waits on out_stall_i.
module grid_dda_column_raycaster (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [5:0]  cell_row_i,
  input  logic [5:0]  cell_col_i,
  input  logic        cell_is_wall_i,
  input  logic [9:0]  screen_column_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [9:0]  out_column_o,
  output logic [8:0]  slice_top_o,
  output logic [8:0]  slice_bottom_o,
  output logic [23:0] slice_color_o,
  output logic        hit_y_side_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [gdr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gdr_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import gdr_pkg::*;

  gdr_cfg_t  cfg_q;
  gdr_head_t head;
  gdr_ctl_t  ctl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.player_x    <= '0;
      cfg_q.player_y    <= '0;
      cfg_q.view_dir_x  <= '0;
      cfg_q.view_dir_y  <= -16'sd16384;
      cfg_q.cam_plane_x <= 16'sd10813;
      cfg_q.cam_plane_y <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PLAYER_X:   cfg_q.player_x    <= cfg_data_i;
        CFG_PLAYER_Y:   cfg_q.player_y    <= cfg_data_i;
        CFG_VIEW_DIR_X: cfg_q.view_dir_x  <= cfg_data_i[15:0];
        CFG_VIEW_DIR_Y: cfg_q.view_dir_y  <= cfg_data_i[15:0];
        CFG_PLANE_X:    cfg_q.cam_plane_x <= cfg_data_i[15:0];
        CFG_PLANE_Y:    cfg_q.cam_plane_y <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  gdr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .cell_row_i     (cell_row_i),
    .cell_col_i     (cell_col_i),
    .cell_is_wall_i (cell_is_wall_i),
    .screen_column_i(screen_column_i),
    .ctl_i          (ctl),
    .head_o         (head)
  );

  gdr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .head_i        (head),
    .ctl_o         (ctl),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_column_o  (out_column_o),
    .slice_top_o   (slice_top_o),
    .slice_bottom_o(slice_bottom_o),
    .slice_color_o (slice_color_o),
    .hit_y_side_o  (hit_y_side_o)
  );

endmodule

/* tb/sv/grid_dda_column_raycaster_test.sv */
// Self-checking testbench of the grid DDA column raycaster.
module grid_dda_column_raycaster_test;
  import gdr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES  = 1200;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 150;

  typedef struct packed {
    logic [9:0]  column;
    logic [8:0]  top;
    logic [8:0]  bottom;
    logic [23:0] color;
    logic        y_side;
  } slice_t;

  typedef struct {
    logic       kind;
    logic [5:0] row;
    logic [5:0] col;
    logic       wall;
    logic [9:0] scol;
    bit         typed;
    bit         has_slice;
    slice_t     slice;
  } vector_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        kind_i;
  logic [5:0]  cell_row_i;
  logic [5:0]  cell_col_i;
  logic        cell_is_wall_i;
  logic [9:0]  screen_column_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [9:0]  out_column_o;
  logic [8:0]  slice_top_o;
  logic [8:0]  slice_bottom_o;
  logic [23:0] slice_color_o;
  logic        hit_y_side_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  grid_dda_column_raycaster DUT (.*);

  // Shadow state of the block.
  bit              wall_bits [MAP_CELLS];
  logic [21:0]     pos_x, pos_y;
  logic signed [15:0] dir_x, dir_y, plane_x, plane_y;

  slice_t pending_slices [$];
  int     error_count = 0;
  bit     calm;
  int     quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  function automatic bit map_blocked(input int mx, input int my);
    if (mx < 0 || my < 0 || mx >= MAP_SIDE || my >= MAP_SIDE) return 1'b1;
    return wall_bits[my * MAP_SIDE + mx];
  endfunction

  // Casts one column through the shadow map; returns 0 when no slice is produced.
  function automatic bit cast_column(input logic [9:0] scol, output slice_t s);
    longint cam, ray_x, ray_y, ray_dist, height, half, top, bottom;
    longint unsigned dx, dy, side_x, side_y, fx, fy;
    int mx, my, sx, sy;
    bit y_hit;
    s = '0;
    if (scol >= SCREEN_W) return 1'b0;
    cam   = ((2 * longint'(scol) - SCREEN_W) * 16384) / SCREEN_W;
    ray_x = longint'(dir_x) + ((longint'(plane_x) * cam) >>> 14);
    ray_y = longint'(dir_y) + ((longint'(plane_y) * cam) >>> 14);
    dx = (ray_x == 0) ? (64'd1 << 40) : (64'd1 << 30) / (ray_x < 0 ? -ray_x : ray_x);
    dy = (ray_y == 0) ? (64'd1 << 40) : (64'd1 << 30) / (ray_y < 0 ? -ray_y : ray_y);
    mx = int'(pos_x >> 16);
    my = int'(pos_y >> 16);
    fx = 64'(pos_x[15:0]);
    fy = 64'(pos_y[15:0]);
    sx = ray_x < 0 ? -1 : 1;
    sy = ray_y < 0 ? -1 : 1;
    side_x = ((ray_x < 0 ? fx : 65536 - fx) * dx) >> 16;
    side_y = ((ray_y < 0 ? fy : 65536 - fy) * dy) >> 16;
    y_hit = 1'b0;
    for (int n = 0; n < STEP_LIMIT; n++) begin
      if (side_x < side_y) begin
        side_x += dx;
        mx += sx;
        y_hit = 1'b0;
      end else begin
        side_y += dy;
        my += sy;
        y_hit = 1'b1;
      end
      if (map_blocked(mx, my)) break;
    end
    ray_dist = y_hit ? longint'(side_y - dy) : longint'(side_x - dx);
    height   = (ray_dist != 0) ? (longint'(SCREEN_H) << 16) / ray_dist : HEIGHT_CAP;
    if (height > HEIGHT_CAP) height = HEIGHT_CAP;
    half   = height / 2;
    top    = HALF_H - half;
    bottom = HALF_H + half;
    if (top < 0) top = 0;
    if (bottom >= SCREEN_H) bottom = SCREEN_H - 1;
    s.column = scol;
    s.top    = top[8:0];
    s.bottom = bottom[8:0];
    s.color  = y_hit ? COLOR_Y_SIDE : COLOR_X_SIDE;
    s.y_side = y_hit;
    return 1'b1;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    case (idx)
      CFG_PLAYER_X:   pos_x = data;
      CFG_PLAYER_Y:   pos_y = data;
      CFG_VIEW_DIR_X: dir_x = data[15:0];
      CFG_VIEW_DIR_Y: dir_y = data[15:0];
      CFG_PLANE_X:    plane_x = data[15:0];
      CFG_PLANE_Y:    plane_y = data[15:0];
      default: ;
    endcase
  endtask

  // Leaves valid high after the transfer so that back-to-back items need one assignment.
  task automatic send_item(input vector_t v);
    slice_t s;
    bit got;
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= v.kind;
    cell_row_i      <= v.row;
    cell_col_i      <= v.col;
    cell_is_wall_i  <= v.wall;
    screen_column_i <= v.scol;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    if (v.kind == KIND_MAP) begin
      wall_bits[{v.row, v.col}] = v.wall;
      got = 1'b0;
    end else begin
      got = cast_column(v.scol, s);
    end
    if (v.typed) begin
      got = v.has_slice;
      s   = v.slice;
    end
    if (got) pending_slices.push_back(s);
  endtask

  task automatic settle();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (pending_slices.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    slice_t want;
    if (out_valid_o && !out_stall_i) begin
      if (pending_slices.size() == 0) begin
        report_mismatch($sformatf("unexpected slice for column %0d", out_column_o));
      end else begin
        want = pending_slices.pop_front();
        if (out_column_o !== want.column)
          report_mismatch($sformatf("column %0d, want %0d", out_column_o, want.column));
        if (slice_top_o !== want.top)
          report_mismatch($sformatf("top %0d, want %0d", slice_top_o, want.top));
        if (slice_bottom_o !== want.bottom)
          report_mismatch($sformatf("bottom %0d, want %0d", slice_bottom_o, want.bottom));
        if (slice_color_o !== want.color)
          report_mismatch($sformatf("color %h, want %h", slice_color_o, want.color));
        if (hit_y_side_o !== want.y_side)
          report_mismatch($sformatf("y side %b, want %b", hit_y_side_o, want.y_side));
      end
    end
    out_stall_i <= rst_ni && !calm && ($urandom_range(0, 99) < 10);
  end

  // Counts cycles without any transfer on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic vector_t map_row(input int r, input int c, input bit w, input int sc);
    vector_t v;
    v = '{kind: KIND_MAP, row: 6'(r), col: 6'(c), wall: w, scol: 10'(sc), typed: 1'b0,
          has_slice: 1'b0, slice: '0};
    return v;
  endfunction

  function automatic vector_t cast_row(input int sc);
    vector_t v;
    v = '{kind: KIND_CAST, row: '0, col: '0, wall: 1'b0, scol: 10'(sc), typed: 1'b0,
          has_slice: 1'b0, slice: '0};
    return v;
  endfunction

  function automatic vector_t typed_cast(input int sc, input bit has, input slice_t s);
    vector_t v;
    v = cast_row(sc);
    v.typed     = 1'b1;
    v.has_slice = has;
    v.slice     = s;
    return v;
  endfunction

  initial begin
    vector_t directed [$];
    vector_t v;
    logic [15:0] pick;
    calm        = 1'b0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    kind_i          <= 1'b0;
    cell_row_i      <= '0;
    cell_col_i      <= '0;
    cell_is_wall_i  <= 1'b0;
    screen_column_i <= '0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    pos_x = '0; pos_y = '0;
    dir_x = 16'sd0; dir_y = -16'sd16384;
    plane_x = 16'sd10813; plane_y = 16'sd0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // After reset the player stands on the map corner facing north: the centre ray
    // leaves the map on its first step at zero distance, a full-height y-side slice.
    directed.push_back(typed_cast(320, 1, '{10'd320, 9'd0, 9'd479, COLOR_Y_SIDE, 1'b1}));
    directed.push_back(cast_row(0));
    directed.push_back(cast_row(639));
    directed.push_back(typed_cast(640, 0, '0));
    directed.push_back(typed_cast(1023, 0, '0));
    directed.push_back(map_row(63, 63, 1, 1023));
    directed.push_back(map_row(0, 0, 1, 0));
    directed.push_back(map_row(0, 0, 0, 0));
    directed.push_back(map_row(10, 5, 1, 0));
    directed.push_back(map_row(5, 10, 1, 0));
    directed.push_back(cast_row(1));
    directed.push_back(cast_row(638));
    foreach (directed[i]) send_item(directed[i]);
    settle();

    // Player in open space looking into walls at several distances.
    write_reg(CFG_PLAYER_X, 22'h0A8000);
    write_reg(CFG_PLAYER_Y, 22'h1F4000);
    cfg_valid_i <= 1'b0;
    send_item(map_row(20, 10, 1, 0));
    send_item(map_row(31, 10, 1, 0));
    send_item(cast_row(320));
    send_item(cast_row(0));
    send_item(cast_row(639));
    send_item(cast_row(100));
    settle();

    for (int p = 0; p < PHASES; p++) begin
      calm = (p == 4);
      case (p)
        1: begin
          write_reg(CFG_PLAYER_X, 22'h3FFFFF);
          write_reg(CFG_PLAYER_Y, 22'h3FFFFF);
          write_reg(CFG_VIEW_DIR_X, 22'h7FFF);
          write_reg(CFG_VIEW_DIR_Y, 22'h7FFF);
          write_reg(CFG_PLANE_X, 22'h7FFF);
          write_reg(CFG_PLANE_Y, 22'h7FFF);
        end
        2: begin
          write_reg(CFG_PLAYER_X, 22'h0);
          write_reg(CFG_PLAYER_Y, 22'h0);
          write_reg(CFG_VIEW_DIR_X, 22'h8000);
          write_reg(CFG_VIEW_DIR_Y, 22'h8000);
          write_reg(CFG_PLANE_X, 22'h8000);
          write_reg(CFG_PLANE_Y, 22'h8000);
        end
        3: begin
          // Null ray: both components zero, so the side sums tie and the first step goes along y.
          write_reg(CFG_PLAYER_X, 22'h200000);
          write_reg(CFG_PLAYER_Y, 22'h200000);
          write_reg(CFG_VIEW_DIR_X, 22'h0);
          write_reg(CFG_VIEW_DIR_Y, 22'h0);
          write_reg(CFG_PLANE_X, 22'h0);
          write_reg(CFG_PLANE_Y, 22'h0);
        end
        default: begin
          write_reg(CFG_PLAYER_X, 22'($urandom_range(0, 22'h3FFFFF)));
          write_reg(CFG_PLAYER_Y, 22'($urandom_range(0, 22'h3FFFFF)));
          for (int r = CFG_VIEW_DIR_X; r <= CFG_PLANE_Y; r++) begin
            pick = $urandom_range(0, 99) < 70 ? 16'($urandom_range(0, 32767) - 16384)
                                              : 16'($urandom());
            write_reg(r[CFG_IDX_W-1:0], {6'($urandom_range(0, 63)), pick});
          end
          if (p == 5) write_reg(3'd7, 22'($urandom()));
          if (p == 6) write_reg(3'd6, 22'($urandom()));
        end
      endcase
      cfg_valid_i <= 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 40) begin
          v = map_row($urandom_range(0, 63), $urandom_range(0, 63),
                      $urandom_range(0, 99) < 35, $urandom_range(0, 1023));
        end else begin
          v = cast_row($urandom_range(0, 99) < 5 ? $urandom_range(640, 1023)
                                                  : $urandom_range(0, 639));
          v.row  = 6'($urandom_range(0, 63));
          v.col  = 6'($urandom_range(0, 63));
          v.wall = 1'($urandom_range(0, 1));
        end
        send_item(v);
      end
      calm = 1'b0;
      settle();
    end

    if (error_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

/* grid_dda_column_raycaster.f */
rtl/gdr_pkg.sv
rtl/gdr_front.sv
rtl/gdr_div.sv
rtl/gdr_back.sv
rtl/grid_dda_column_raycaster.sv
tb/sv/grid_dda_column_raycaster_test.sv
